[hdl/swa_pkg.sv]
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants
// Opcodes, result actions, register indexes, parse states and the bundles
// that pass between the stop-and-wait acknowledge receiver modules.
// ----------------------------------------------------------------------------
package swa_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned TRIES_W = 4;
  localparam int unsigned CIDX_W  = 3;

  // input opcodes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // result actions
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RETX = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FAIL = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FLAG    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_ADDR    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_READY0  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_READY1  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_REJECT0 = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_REJECT1 = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_MAXTRY  = 3'd6;

  // saturation point of the try counter
  localparam logic [TRIES_W-1:0] TRIES_MAX = 4'd15;

  // supervisory frame parser states
  typedef enum logic [6:0] {
    PS_HUNT = 7'b0000001,
    PS_FLAG = 7'b0000010,
    PS_ADDR = 7'b0000100,
    PS_RR_C = 7'b0001000,
    PS_RR_K = 7'b0010000,
    PS_RJ_C = 7'b0100000,
    PS_RJ_K = 7'b1000000
  } pstate_t;

  // configuration register set
  typedef struct packed {
    logic [BYTE_W-1:0]  flag_byte;
    logic [BYTE_W-1:0]  address_byte;
    logic [BYTE_W-1:0]  ready0_code;
    logic [BYTE_W-1:0]  ready1_code;
    logic [BYTE_W-1:0]  reject0_code;
    logic [BYTE_W-1:0]  reject1_code;
    logic [TRIES_W-1:0] max_tries;
  } cfg_t;

  // one input beat
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic               seq_now;
    logic [TRIES_W-1:0] tries_now;
  } res_t;

endpackage

[hdl/swa_cfg_regs.sv]
// ----------------------------------------------------------------------------
// swa_cfg_regs: configuration register file
// Seven write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module swa_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [swa_pkg::CIDX_W-1:0] cfg_idx,
  input  logic [swa_pkg::BYTE_W-1:0] cfg_wdata,
  output swa_pkg::cfg_t              cfg
);
  import swa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // index decode, writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FLAG:    cfg_nxt.flag_byte    = cfg_wdata;
        CFG_ADDR:    cfg_nxt.address_byte = cfg_wdata;
        CFG_READY0:  cfg_nxt.ready0_code  = cfg_wdata;
        CFG_READY1:  cfg_nxt.ready1_code  = cfg_wdata;
        CFG_REJECT0: cfg_nxt.reject0_code = cfg_wdata;
        CFG_REJECT1: cfg_nxt.reject1_code = cfg_wdata;
        CFG_MAXTRY:  cfg_nxt.max_tries    = cfg_wdata[TRIES_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  // register storage with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte    <= 8'd126;
      cfg_r.address_byte <= 8'd3;
      cfg_r.ready0_code  <= 8'd5;
      cfg_r.ready1_code  <= 8'd133;
      cfg_r.reject0_code <= 8'd1;
      cfg_r.reject1_code <= 8'd129;
      cfg_r.max_tries    <= 4'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/swa_step.sv]
// ----------------------------------------------------------------------------
// swa_step: receiver state and per-beat update
// Holds the parser state, sequence bit, try count and wait flag, and works
// out the result and next state of one input beat in a single pass.
// ----------------------------------------------------------------------------
module swa_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  swa_pkg::item_t item,
  input  swa_pkg::cfg_t  cfg,
  output swa_pkg::res_t  res
);
  import swa_pkg::*;

  pstate_t            ps_r, ps_nxt;
  logic               seq_r, seq_nxt;
  logic [TRIES_W-1:0] tries_r, tries_nxt;
  logic               wait_r, wait_nxt;
  logic [ACT_W-1:0]   act;

  logic               is_flag;
  logic               is_rdy, is_rej, rdy_ok, rej_ok;
  logic               rr_chk, rj_chk;
  logic [TRIES_W-1:0] tries_inc;
  logic               retx_fail;
  logic [BYTE_W-1:0]  b;

  // byte matches against the configured codes
  always_comb begin
    b       = item.rx_byte;
    is_flag = (b == cfg.flag_byte);
    is_rdy  = (b == cfg.ready0_code) || (b == cfg.ready1_code);
    is_rej  = (b == cfg.reject0_code) || (b == cfg.reject1_code);
    rdy_ok  = (!seq_r && (b == cfg.ready1_code)) || (seq_r && (b == cfg.ready0_code));
    rej_ok  = (!seq_r && (b == cfg.reject0_code)) || (seq_r && (b == cfg.reject1_code));
    rr_chk  = (b == (cfg.address_byte ^ cfg.ready0_code)) ||
              (b == (cfg.address_byte ^ cfg.ready1_code));
    rj_chk  = (b == (cfg.address_byte ^ cfg.reject0_code)) ||
              (b == (cfg.address_byte ^ cfg.reject1_code));
  end

  // saturating try count and limit check for a retransmit request
  assign tries_inc = (tries_r < TRIES_MAX) ? tries_r + 4'd1 : tries_r;
  assign retx_fail = (tries_inc >= cfg.max_tries);

  // next state and action
  always_comb begin
    ps_nxt    = ps_r;
    seq_nxt   = seq_r;
    tries_nxt = tries_r;
    wait_nxt  = wait_r;
    act       = ACT_NONE;
    case (item.opcode)
      OP_START: begin
        wait_nxt  = 1'b1;
        tries_nxt = '0;
        ps_nxt    = PS_HUNT;
      end
      OP_BYTE: begin
        if (wait_r) begin
          unique case (ps_r)
            PS_FLAG: begin
              ps_nxt = is_flag ? PS_FLAG : ((b == cfg.address_byte) ? PS_ADDR : PS_HUNT);
            end
            PS_ADDR: begin
              if (is_flag)      ps_nxt = PS_FLAG;
              else if (is_rdy)  ps_nxt = rdy_ok ? PS_RR_C : PS_HUNT;
              else if (is_rej)  ps_nxt = rej_ok ? PS_RJ_C : PS_HUNT;
              else              ps_nxt = PS_HUNT;
            end
            PS_RR_C: begin
              if (is_flag)      ps_nxt = PS_FLAG;
              else if (rr_chk)  ps_nxt = PS_RR_K;
              else              ps_nxt = PS_HUNT;
            end
            PS_RR_K: begin
              ps_nxt = PS_HUNT;
              if (is_flag) begin
                seq_nxt  = ~seq_r;
                wait_nxt = 1'b0;
                act      = ACT_ACK;
              end
            end
            PS_RJ_C: begin
              if (is_flag)      ps_nxt = PS_FLAG;
              else if (rj_chk)  ps_nxt = PS_RJ_K;
              else              ps_nxt = PS_HUNT;
            end
            PS_RJ_K: begin
              ps_nxt = PS_HUNT;
              if (is_flag) begin
                tries_nxt = tries_inc;
                if (retx_fail) begin
                  wait_nxt = 1'b0;
                  act      = ACT_FAIL;
                end else begin
                  act      = ACT_RETX;
                end
              end
            end
            default: begin
              ps_nxt = is_flag ? PS_FLAG : PS_HUNT;
            end
          endcase
        end
      end
      OP_TICK: begin
        // timeout leaves the parser alone unless the wait ends
        if (wait_r) begin
          tries_nxt = tries_inc;
          if (retx_fail) begin
            wait_nxt = 1'b0;
            ps_nxt   = PS_HUNT;
            act      = ACT_FAIL;
          end else begin
            act      = ACT_RETX;
          end
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  // state registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r    <= PS_HUNT;
      seq_r   <= 1'b0;
      tries_r <= '0;
      wait_r  <= 1'b0;
    end else if (adv) begin
      ps_r    <= ps_nxt;
      seq_r   <= seq_nxt;
      tries_r <= tries_nxt;
      wait_r  <= wait_nxt;
    end
  end

  assign res.action    = act;
  assign res.seq_now   = seq_nxt;
  assign res.tries_now = tries_nxt;

endmodule

[hdl/swa_out_reg.sv]
// ----------------------------------------------------------------------------
// swa_out_reg: result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module swa_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  swa_pkg::res_t               res,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swa_pkg::ACT_W-1:0]   out_action,
  output logic                        out_seq_now,
  output logic [swa_pkg::TRIES_W-1:0] out_tries_now
);
  import swa_pkg::*;

  logic vld_r;
  res_t res_r;

  // register can take a beat when empty or being drained
  assign free = !vld_r || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid     = vld_r;
  assign out_action    = res_r.action;
  assign out_seq_now   = res_r.seq_now;
  assign out_tries_now = res_r.tries_now;

endmodule

[hdl/stop_wait_ack_receiver_top.sv]
// ----------------------------------------------------------------------------
// stop_wait_ack_receiver_top: stop-and-wait sender, answer receiver
// Waits for the answer to a sent frame, parses supervisory frames and
// reports acknowledge, retransmit, failure or no action for every input beat.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid/in_ready, in_opcode, in_rx_byte  | to block
//  out      | out_valid/out_ready, out_action,          | from block
//           | out_seq_now, out_tries_now                |
//  cfg      | cfg_we, cfg_idx, cfg_wdata                | to block
//
// one beat per cycle sustained while results are taken; each beat gives
// exactly one result beat, which passes through the input register, then
// the state update into the result register
// a full result register that is not taken stalls the state update and,
// once the input register is also full, drops in_ready
// synchronous active-low reset clears the pipeline and state and sets the configuration registers
// ----------------------------------------------------------------------------
module stop_wait_ack_receiver_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swa_pkg::OP_W-1:0]    in_opcode,
  input  logic [swa_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swa_pkg::ACT_W-1:0]   out_action,
  output logic                        out_seq_now,
  output logic [swa_pkg::TRIES_W-1:0] out_tries_now,
  input  logic                        cfg_we,
  input  logic [swa_pkg::CIDX_W-1:0]  cfg_idx,
  input  logic [swa_pkg::BYTE_W-1:0]  cfg_wdata
);
  import swa_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  item_vld_r;
  logic  out_free;
  logic  adv;
  res_t  res;

  // configuration registers
  swa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register handshake
  assign adv      = item_vld_r && out_free;
  assign in_ready = !item_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode  <= in_opcode;
      item_r.rx_byte <= in_rx_byte;
    end
  end

  // state update
  swa_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  swa_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (adv),
    .res           (res),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_action    (out_action),
    .out_seq_now   (out_seq_now),
    .out_tries_now (out_tries_now)
  );

endmodule

[sim/swa_checker.sv]
// ----------------------------------------------------------------------------
// swa_checker: answer predictor and result scoreboard
// Watches the input, result and register write ports of the stop-and-wait
// acknowledge receiver. It keeps its own copy of the parser, sequence bit,
// try count and registers, predicts the report for every accepted input
// beat and compares each result beat with the oldest pending report.
// ----------------------------------------------------------------------------
module swa_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [swa_pkg::OP_W-1:0]    in_opcode,
  input  logic [swa_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [swa_pkg::ACT_W-1:0]   out_action,
  input  logic                        out_seq_now,
  input  logic [swa_pkg::TRIES_W-1:0] out_tries_now,
  input  logic                        cfg_we,
  input  logic [swa_pkg::CIDX_W-1:0]  cfg_idx,
  input  logic [swa_pkg::BYTE_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          awaited
);
  import swa_pkg::*;

  // mirrored link state and registers
  cfg_t               regs;
  pstate_t            hunt_st;
  logic               seq_bit_m;
  logic [TRIES_W-1:0] tries_m;
  logic               in_wait;

  // reports still owed by the block, oldest first
  res_t               owed_reports[$];

  // one more send attempt: retransmit, or give up at the limit
  function automatic logic [ACT_W-1:0] count_retry();
    if (tries_m != TRIES_MAX) tries_m = tries_m + 1'b1;
    if (tries_m >= regs.max_tries) begin
      in_wait = 1'b0;
      hunt_st = PS_HUNT;
      return ACT_FAIL;
    end
    return ACT_RETX;
  endfunction

  // supervisory frame parser, one received byte
  function automatic logic [ACT_W-1:0] parse_rx(input logic [BYTE_W-1:0] b);
    logic             is_flag;
    logic [ACT_W-1:0] act;
    is_flag = (b == regs.flag_byte);
    act     = ACT_NONE;
    case (hunt_st)
      PS_FLAG: begin
        if (is_flag) hunt_st = PS_FLAG;
        else if (b == regs.address_byte) hunt_st = PS_ADDR;
        else hunt_st = PS_HUNT;
      end
      PS_ADDR: begin
        if (is_flag) begin
          hunt_st = PS_FLAG;
        end else if (b == regs.ready0_code || b == regs.ready1_code) begin
          // ready must name the next sequence number
          if ((!seq_bit_m && b == regs.ready1_code) || (seq_bit_m && b == regs.ready0_code))
            hunt_st = PS_RR_C;
          else
            hunt_st = PS_HUNT;
        end else if (b == regs.reject0_code || b == regs.reject1_code) begin
          // reject must name the current sequence number
          if ((!seq_bit_m && b == regs.reject0_code) || (seq_bit_m && b == regs.reject1_code))
            hunt_st = PS_RJ_C;
          else
            hunt_st = PS_HUNT;
        end else begin
          hunt_st = PS_HUNT;
        end
      end
      PS_RR_C: begin
        if (is_flag) hunt_st = PS_FLAG;
        else if (b == (regs.address_byte ^ regs.ready0_code) ||
                 b == (regs.address_byte ^ regs.ready1_code)) hunt_st = PS_RR_K;
        else hunt_st = PS_HUNT;
      end
      PS_RR_K: begin
        hunt_st = PS_HUNT;
        if (is_flag) begin
          seq_bit_m = ~seq_bit_m;
          in_wait   = 1'b0;
          act       = ACT_ACK;
        end
      end
      PS_RJ_C: begin
        if (is_flag) hunt_st = PS_FLAG;
        else if (b == (regs.address_byte ^ regs.reject0_code) ||
                 b == (regs.address_byte ^ regs.reject1_code)) hunt_st = PS_RJ_K;
        else hunt_st = PS_HUNT;
      end
      PS_RJ_K: begin
        hunt_st = PS_HUNT;
        if (is_flag) act = count_retry();
      end
      default: begin
        if (is_flag) hunt_st = PS_FLAG;
        else hunt_st = PS_HUNT;
      end
    endcase
    return act;
  endfunction

  // report caused by one input beat
  function automatic res_t predict_report(input logic [OP_W-1:0] op,
                                          input logic [BYTE_W-1:0] b);
    res_t r;
    r.action = ACT_NONE;
    if (op == OP_START) begin
      in_wait = 1'b1;
      tries_m = '0;
      hunt_st = PS_HUNT;
    end else if (op == OP_BYTE && in_wait) begin
      r.action = parse_rx(b);
    end else if (op == OP_TICK && in_wait) begin
      r.action = count_retry();
    end
    r.seq_now   = seq_bit_m;
    r.tries_now = tries_m;
    return r;
  endfunction

  // watch all three ports at each edge
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      regs.flag_byte    = 8'd126;
      regs.address_byte = 8'd3;
      regs.ready0_code  = 8'd5;
      regs.ready1_code  = 8'd133;
      regs.reject0_code = 8'd1;
      regs.reject1_code = 8'd129;
      regs.max_tries    = 4'd3;
      hunt_st           = PS_HUNT;
      seq_bit_m         = 1'b0;
      tries_m           = '0;
      in_wait           = 1'b0;
      owed_reports.delete();
      fail_count        = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FLAG:    regs.flag_byte    = cfg_wdata;
          CFG_ADDR:    regs.address_byte = cfg_wdata;
          CFG_READY0:  regs.ready0_code  = cfg_wdata;
          CFG_READY1:  regs.ready1_code  = cfg_wdata;
          CFG_REJECT0: regs.reject0_code = cfg_wdata;
          CFG_REJECT1: regs.reject1_code = cfg_wdata;
          CFG_MAXTRY:  regs.max_tries    = cfg_wdata[TRIES_W-1:0];
          default: ;
        endcase
      end
      // input beat
      if (in_valid && in_ready)
        owed_reports.push_back(predict_report(in_opcode, in_rx_byte));
      // result beat
      if (out_valid && out_ready) begin
        if (owed_reports.size() == 0) begin
          $error("unexpected result beat: action %0d seq_now %0d tries_now %0d",
                 out_action, out_seq_now, out_tries_now);
          fail_count++;
        end else begin
          want = owed_reports.pop_front();
          if (out_action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, out_action);
            fail_count++;
          end
          if (out_seq_now !== want.seq_now) begin
            $error("seq_now: expected %0d, actual %0d", want.seq_now, out_seq_now);
            fail_count++;
          end
          if (out_tries_now !== want.tries_now) begin
            $error("tries_now: expected %0d, actual %0d", want.tries_now, out_tries_now);
            fail_count++;
          end
        end
      end
    end
    awaited = owed_reports.size();
  end

endmodule

[sim/tb_stop_wait_ack_receiver_top.sv]
// ----------------------------------------------------------------------------
// tb_stop_wait_ack_receiver_top: testbench of the acknowledge receiver
// Drives start, received byte and timeout beats under several register
// settings: a directed opening, then sessions of well-formed ready and
// reject frames, retry storms, broken frames and noise. Random gaps on the
// input and stalls on the result side, one long result hold-off, and a
// quiet final phase. A checker beside the block predicts every report.
// ----------------------------------------------------------------------------
module tb_stop_wait_ack_receiver_top;
  import swa_pkg::*;

  localparam int NUM_PHASES  = 6;
  localparam int PHASE_BEATS = 75;
  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 4;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_opcode;
  logic [BYTE_W-1:0]  in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [ACT_W-1:0]   out_action;
  logic               out_seq_now;
  logic [TRIES_W-1:0] out_tries_now;
  logic               cfg_we;
  logic [CIDX_W-1:0]  cfg_idx;
  logic [BYTE_W-1:0]  cfg_wdata;

  int   fail_count;
  int   awaited;
  int   beats_sent;
  int   hold_reqs;
  int   quiet_cycles;
  bit   send_gaps;
  bit   sink_stalls;
  cfg_t link_cfg;

  stop_wait_ack_receiver_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_seq_now  (out_seq_now),
    .out_tries_now(out_tries_now),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata)
  );

  swa_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_seq_now  (out_seq_now),
    .out_tries_now(out_tries_now),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .awaited      (awaited)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin : sink
    int holds_done;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one input beat and wait until it is taken
  task automatic offer_beat(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // sender pause until every report is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // write the whole register set
  task automatic load_regs(input cfg_t c);
    link_cfg = c;
    put_reg(CFG_FLAG,    c.flag_byte);
    put_reg(CFG_ADDR,    c.address_byte);
    put_reg(CFG_READY0,  c.ready0_code);
    put_reg(CFG_READY1,  c.ready1_code);
    put_reg(CFG_REJECT0, c.reject0_code);
    put_reg(CFG_REJECT1, c.reject1_code);
    put_reg(CFG_MAXTRY,  {{(BYTE_W-TRIES_W){1'b0}}, c.max_tries});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // register set per phase: both extremes, colliding codes, then random
  function automatic cfg_t phase_regs(input int ph);
    cfg_t c;
    c.flag_byte    = 8'($urandom_range(0, 255));
    c.address_byte = 8'($urandom_range(0, 255));
    c.ready0_code  = 8'($urandom_range(0, 255));
    c.ready1_code  = 8'($urandom_range(0, 255));
    c.reject0_code = 8'($urandom_range(0, 255));
    c.reject1_code = 8'($urandom_range(0, 255));
    c.max_tries    = 4'($urandom_range(1, 15));
    case (ph)
      0: begin
        c.flag_byte    = 8'h00;
        c.address_byte = 8'hFF;
        c.ready0_code  = 8'h01;
        c.ready1_code  = 8'hFE;
        c.reject0_code = 8'h80;
        c.reject1_code = 8'h7F;
        c.max_tries    = 4'd1;
      end
      1: begin
        c.flag_byte    = 8'hFF;
        c.address_byte = 8'h00;
        c.ready0_code  = 8'h55;
        c.ready1_code  = 8'hAA;
        c.reject0_code = 8'h0F;
        c.reject1_code = 8'hF0;
        c.max_tries    = 4'd15;
      end
      2: begin
        // reject codes shadowed by ready codes
        c.reject0_code = c.ready0_code;
        c.reject1_code = c.ready1_code;
      end
      default: ;
    endcase
    return c;
  endfunction

  // one supervisory answer frame, optionally damaged or cut short
  task automatic offer_answer(input bit is_reject, input bit damaged);
    logic [BYTE_W-1:0] frame_b[5];
    logic [BYTE_W-1:0] code0;
    logic [BYTE_W-1:0] code1;
    int                n_bytes;
    int                pos;
    code0 = is_reject ? link_cfg.reject0_code : link_cfg.ready0_code;
    code1 = is_reject ? link_cfg.reject1_code : link_cfg.ready1_code;
    frame_b[0] = link_cfg.flag_byte;
    frame_b[1] = link_cfg.address_byte;
    frame_b[2] = $urandom_range(0, 1) ? code1 : code0;
    frame_b[3] = link_cfg.address_byte ^ ($urandom_range(0, 1) ? code1 : code0);
    frame_b[4] = link_cfg.flag_byte;
    n_bytes = 5;
    if (damaged) begin
      pos = $urandom_range(0, 4);
      if ($urandom_range(0, 1)) frame_b[pos] = 8'($urandom_range(0, 255));
      else n_bytes = pos;
    end
    // doubled opening flag now and then
    if ($urandom_range(0, 7) == 0) offer_beat(OP_BYTE, link_cfg.flag_byte);
    for (int k = 0; k < n_bytes; k++) offer_beat(OP_BYTE, frame_b[k]);
  endtask

  // one wait: start, then answers, ticks and noise
  task automatic run_session();
    int steps;
    offer_beat(OP_START, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) begin
      // retry storm up to and past the limit
      repeat (int'(link_cfg.max_tries) + 1) begin
        if ($urandom_range(0, 2) == 0) offer_answer(1'b1, 1'b0);
        else offer_beat(OP_TICK, 8'($urandom_range(0, 255)));
      end
    end else begin
      steps = $urandom_range(1, 8);
      repeat (steps) begin
        case ($urandom_range(0, 9))
          0, 1, 2: offer_answer(1'b0, 1'b0);
          3, 4:    offer_answer(1'b1, 1'b0);
          5, 6:    offer_beat(OP_TICK, 8'($urandom_range(0, 255)));
          7:       offer_answer(1'($urandom_range(0, 1)), 1'b1);
          8:       offer_beat(OP_BYTE, 8'($urandom_range(0, 255)));
          default: offer_beat(OP_BYTE, link_cfg.flag_byte);
        endcase
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int phase_start;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_START;
    in_rx_byte  <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_FLAG;
    cfg_wdata   <= '0;
    beats_sent   = 0;
    hold_reqs    = 0;
    quiet_cycles = 0;
    send_gaps    = 1'b1;
    sink_stalls  = 1'b1;
    link_cfg.flag_byte    = 8'd126;
    link_cfg.address_byte = 8'd3;
    link_cfg.ready0_code  = 8'd5;
    link_cfg.ready1_code  = 8'd133;
    link_cfg.reject0_code = 8'd1;
    link_cfg.reject1_code = 8'd129;
    link_cfg.max_tries    = 4'd3;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening under reset registers
    // beats while idle are ignored
    offer_beat(OP_BYTE, 8'hFF);
    offer_beat(OP_TICK, 8'h00);
    // good ready frame, check byte built from the other ready code
    offer_beat(OP_START, 8'h00);
    offer_beat(OP_BYTE, link_cfg.flag_byte);
    offer_beat(OP_BYTE, link_cfg.address_byte);
    offer_beat(OP_BYTE, link_cfg.ready1_code);
    offer_beat(OP_BYTE, link_cfg.address_byte ^ link_cfg.ready0_code);
    offer_beat(OP_BYTE, link_cfg.flag_byte);
    // reject for the current number, then ticks up to failure
    offer_beat(OP_START, 8'hFF);
    offer_beat(OP_BYTE, link_cfg.flag_byte);
    offer_beat(OP_BYTE, link_cfg.address_byte);
    offer_beat(OP_BYTE, link_cfg.reject1_code);
    offer_beat(OP_BYTE, link_cfg.address_byte ^ link_cfg.reject1_code);
    offer_beat(OP_BYTE, link_cfg.flag_byte);
    offer_beat(OP_TICK, 8'hFF);
    offer_beat(OP_TICK, 8'h00);
    // flag restart, ready with good check but no closing flag
    offer_beat(OP_START, 8'h00);
    offer_beat(OP_BYTE, link_cfg.flag_byte);
    offer_beat(OP_BYTE, link_cfg.flag_byte);
    offer_beat(OP_BYTE, link_cfg.address_byte);
    offer_beat(OP_BYTE, link_cfg.ready0_code);
    offer_beat(OP_BYTE, link_cfg.address_byte ^ link_cfg.ready1_code);
    offer_beat(OP_BYTE, 8'h00);
    offer_beat(OP_TICK, 8'h00);
    // start while already waiting
    offer_beat(OP_START, 8'hFF);

    // random sessions, one register set per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      load_regs(phase_regs(ph));
      if (ph == NUM_PHASES - 1) begin
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
      end
      // long result hold-off while the sender keeps offering
      if (ph == 2) hold_reqs++;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) run_session();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/swa_pkg.sv
hdl/swa_cfg_regs.sv
hdl/swa_step.sv
hdl/swa_out_reg.sv
hdl/stop_wait_ack_receiver_top.sv
sim/swa_checker.sv
sim/tb_stop_wait_ack_receiver_top.sv
